[rtl/core/tcp_stream_reassembler_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the TCP stream reassembler
// Shared property wrappers, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TCP_STREAM_REASSEMBLER_TOP_MACROS_SVH
`define TCP_STREAM_REASSEMBLER_TOP_MACROS_SVH

// same-cycle implication
`define TSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tsr_pkg.sv]
// ----------------------------------------------------------------------------
// TCP stream reassembler package
// Shared item, result and status types and fixed constants.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam logic       FUNC_DATA   = 1'b0;
    localparam logic       FUNC_END    = 1'b1;
    localparam logic [6:0] MAX_RELEASE = 7'd64;
    localparam logic [6:0] HELD_MAX    = 7'd127;

    typedef struct packed {
        logic        is_end;
        logic [7:0]  byte_value;
        logic [31:0] stream_index;
        logic [6:0]  limit;
    } t_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic [31:0] ack_position;
        logic [6:0]  held_count;
        logic        stream_ended;
    } t_result;

    typedef struct packed {
        logic clearing;
    } t_bk_status;

endpackage

[rtl/core/tsr_if.sv]
// ----------------------------------------------------------------------------
// TCP stream reassembler channels
// Input word channel and result word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsr_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  byte_value;
    logic [31:0] stream_index;
    logic [6:0]  out_space;

    modport source (output valid, func, byte_value, stream_index, out_space, input ready);
    modport sink   (input valid, func, byte_value, stream_index, out_space, output ready);
endinterface

interface tsr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [31:0] ack_position;
    logic [6:0]  held_count;
    logic        stream_ended;

    modport source (output valid, out_byte, byte_valid, last, ack_position, held_count,
                    stream_ended, input ready);
    modport sink   (input valid, out_byte, byte_valid, last, ack_position, held_count,
                    stream_ended, output ready);
endinterface

[rtl/core/tsr_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsr_ram #(
    parameter int WIDTH  = 9,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/tsr_front.sv]
// ----------------------------------------------------------------------------
// TCP stream reassembler front end
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module tsr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tsr_in_if.sink              i_in,
    input  tsr_pkg::t_bk_status i_status,
    output logic                o_q_valid,
    output tsr_pkg::t_item      o_q_item,
    input  logic                i_q_pop
);

    localparam int QDEPTH = 2;

    tsr_pkg::t_item r_q [QDEPTH];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count, n_count;
    logic           w_push;
    tsr_pkg::t_item w_item;

    assign i_in.ready = (r_count != 2'(QDEPTH)) && !i_status.clearing;
    assign w_push     = i_in.valid && i_in.ready;

    always_comb begin
        w_item.is_end       = (i_in.func == tsr_pkg::FUNC_END);
        w_item.byte_value   = i_in.byte_value;
        w_item.stream_index = i_in.stream_index;
        w_item.limit        = (i_in.out_space > tsr_pkg::MAX_RELEASE) ?
                              tsr_pkg::MAX_RELEASE : i_in.out_space;
    end

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_q_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_q[r_rd_ptr];

endmodule

[rtl/core/tsr_back.sv]
// ----------------------------------------------------------------------------
// TCP stream reassembler back end
// Stores bytes in the window RAM, releases in-order bytes, drives results.
// ----------------------------------------------------------------------------
module tsr_back #(
    parameter int WINDOW = 64,
    parameter int SLOT_W = $clog2(WINDOW),
    parameter int CNT_W  = $clog2(WINDOW + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  tsr_pkg::t_item       i_q_item,
    output logic                 o_q_pop,
    output tsr_pkg::t_bk_status  o_status,
    tsr_out_if.source            o_out
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_SLOT = 3'd3;
    localparam logic [2:0] ST_SWR  = 3'd4;
    localparam logic [2:0] ST_DRD  = 3'd5;
    localparam logic [2:0] ST_DCHK = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [SLOT_W:0]   WIN_EXT   = (SLOT_W + 1)'(WINDOW);

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_clr_addr, n_clr_addr;
    logic [31:0]       r_ne, n_ne;
    logic              r_end_seen, n_end_seen;
    logic [31:0]       r_end_pos, n_end_pos;
    logic              r_ended, n_ended;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_held, n_held;
    logic [6:0]        r_n, n_n;
    logic              r_pend_valid, n_pend_valid;
    tsr_pkg::t_result  r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    tsr_pkg::t_result  r_out, n_out;
    tsr_pkg::t_item    r_item, n_item;
    logic [SLOT_W-1:0] r_off, n_off;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    logic [8:0]        w_wdata;
    logic              w_re;
    logic [SLOT_W-1:0] w_raddr;
    logic [8:0]        w_rdata;

    logic [31:0]       w_off;
    logic [31:0]       w_end_off;
    logic              w_keep;
    logic [SLOT_W:0]   w_sum;
    logic [SLOT_W-1:0] w_slot;
    logic [SLOT_W-1:0] w_head_inc;
    logic [31:0]       w_ne_inc;
    logic [CNT_W-1:0]  w_held_dec;
    logic              w_ended_inc;
    logic              w_out_free;

    function automatic logic [6:0] sat_held(input logic [CNT_W-1:0] held);
        logic [6:0] res;
        if (held > CNT_W'(tsr_pkg::HELD_MAX)) begin
            res = tsr_pkg::HELD_MAX;
        end else begin
            res = 7'(held);
        end
        return res;
    endfunction

    tsr_ram #(
        .WIDTH (9),
        .DEPTH (WINDOW),
        .ADDR_W(SLOT_W)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_off      = r_item.stream_index - r_ne;
    assign w_end_off  = r_end_pos - r_ne;
    assign w_keep     = (w_off < 32'(WINDOW)) && !(r_end_seen && (w_off >= w_end_off));
    assign w_sum      = {1'b0, r_head} + {1'b0, r_off};
    assign w_slot     = (w_sum >= WIN_EXT) ? SLOT_W'(w_sum - WIN_EXT) : w_sum[SLOT_W-1:0];
    assign w_head_inc = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign w_ne_inc   = r_ne + 32'd1;
    assign w_held_dec = r_held - 1'b1;
    assign w_ended_inc = r_end_seen && (w_ne_inc == r_end_pos);
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_ne         = r_ne;
        n_end_seen   = r_end_seen;
        n_end_pos    = r_end_pos;
        n_ended      = r_ended;
        n_head       = r_head;
        n_held       = r_held;
        n_n          = r_n;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        n_item       = r_item;
        n_off        = r_off;
        n_slot       = r_slot;
        o_q_pop      = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_head;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = r_head;

        unique case (r_state)
            ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_n     = '0;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_ended) begin
                    n_state = ST_FIN;
                end else if (r_item.is_end) begin
                    n_end_seen = 1'b1;
                    n_end_pos  = r_item.stream_index;
                    n_ended    = (r_item.stream_index == r_ne);
                    n_state    = ST_DRD;
                end else if (w_keep) begin
                    n_off   = w_off[SLOT_W-1:0];
                    n_state = ST_SLOT;
                end else begin
                    n_state = ST_DRD;
                end
            end
            ST_SLOT: begin
                w_re    = 1'b1;
                w_raddr = w_slot;
                n_slot  = w_slot;
                n_state = ST_SWR;
            end
            ST_SWR: begin
                w_we    = 1'b1;
                w_waddr = r_slot;
                w_wdata = {1'b1, r_item.byte_value};
                if (!w_rdata[8]) begin
                    n_held = r_held + 1'b1;
                end
                n_state = ST_DRD;
            end
            ST_DRD: begin
                if ((r_n < r_item.limit) && !r_ended) begin
                    w_re    = 1'b1;
                    w_raddr = r_head;
                    n_state = ST_DCHK;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DCHK: begin
                if (!w_rdata[8]) begin
                    n_state = ST_FIN;
                end else if (!r_pend_valid || w_out_free) begin
                    w_we    = 1'b1;
                    w_waddr = r_head;
                    n_head  = w_head_inc;
                    n_ne    = w_ne_inc;
                    n_held  = w_held_dec;
                    n_ended = w_ended_inc;
                    n_n     = r_n + 7'd1;
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                    end
                    n_pend_valid        = 1'b1;
                    n_pend.out_byte     = w_rdata[7:0];
                    n_pend.byte_valid   = 1'b1;
                    n_pend.last         = 1'b0;
                    n_pend.ack_position = w_ne_inc;
                    n_pend.held_count   = sat_held(w_held_dec);
                    n_pend.stream_ended = w_ended_inc;
                    n_state             = ST_DRD;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pend_valid) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out.out_byte     = '0;
                        n_out.byte_valid   = 1'b0;
                        n_out.last         = 1'b1;
                        n_out.ack_position = r_ne;
                        n_out.held_count   = sat_held(r_held);
                        n_out.stream_ended = r_ended;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_clr_addr   <= '0;
            r_ne         <= '0;
            r_end_seen   <= 1'b0;
            r_end_pos    <= '0;
            r_ended      <= 1'b0;
            r_head       <= '0;
            r_held       <= '0;
            r_n          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_ne         <= n_ne;
            r_end_seen   <= n_end_seen;
            r_end_pos    <= n_end_pos;
            r_ended      <= n_ended;
            r_head       <= n_head;
            r_held       <= n_held;
            r_n          <= n_n;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        r_item <= n_item;
        r_off  <= n_off;
        r_slot <= n_slot;
    end

    assign o_status.clearing  = (r_state == ST_CLR);

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out.out_byte;
    assign o_out.byte_valid   = r_out.byte_valid;
    assign o_out.last         = r_out.last;
    assign o_out.ack_position = r_out.ack_position;
    assign o_out.held_count   = r_out.held_count;
    assign o_out.stream_ended = r_out.stream_ended;

endmodule

[rtl/core/tcp_stream_reassembler_top.sv]
// ----------------------------------------------------------------------------
// TCP stream reassembler top level
// Window-based in-order reassembly of indexed stream bytes with end mark.
// ----------------------------------------------------------------------------
//   channel   dir   words
//   i_in      in    func, byte_value, stream_index, out_space
//   o_out     out   out_byte, byte_valid, last, ack_position, held_count,
//                   stream_ended
//
// In the back end each input word is evaluated first. Once the stream has
// ended it goes straight to the result; a mark or a dropped byte goes to
// the release loop, and a byte to store first reads and writes its slot.
// Release reads each head slot (registered read), ending at an empty head.
// After reset a clearing pass runs over every slot of the window RAM;
// no input word is taken during it.
// A two-word queue lets input words arrive while the back end drains, and
// the output register lets the back end move on while a result waits.
// ----------------------------------------------------------------------------
`include "tcp_stream_reassembler_top_macros.svh"

module tcp_stream_reassembler_top #(
    parameter int WINDOW = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsr_in_if.sink    i_in,
    tsr_out_if.source o_out
);

    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int HELD_BOUND = (WINDOW > 127) ? 127 : WINDOW;

    logic                w_q_valid;
    tsr_pkg::t_item      w_q_item;
    logic                w_q_pop;
    tsr_pkg::t_bk_status w_status;

    tsr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (w_status),
        .o_q_valid(w_q_valid),
        .o_q_item (w_q_item),
        .i_q_pop  (w_q_pop)
    );

    tsr_back #(
        .WINDOW(WINDOW),
        .SLOT_W(SLOT_W),
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .i_q_item (w_q_item),
        .o_q_pop  (w_q_pop),
        .o_status (w_status),
        .o_out    (o_out)
    );

    `TSR_ASSERT_IMP(a_pop_has_word, i_clk, i_rst_n, w_q_pop, w_q_valid, "pop from empty queue")
    `TSR_ASSERT_IMP(a_no_accept_clear, i_clk, i_rst_n, w_status.clearing, !i_in.ready, "input taken during clearing pass")
    `TSR_ASSERT_NXT(a_no_result_clear, i_clk, i_rst_n, w_status.clearing, !o_out.valid, "result during clearing pass")
    `TSR_ASSERT_IMP(a_status_is_last, i_clk, i_rst_n, o_out.valid && !o_out.byte_valid, o_out.last, "status word not last")
    `TSR_ASSERT_IMP(a_held_bound, i_clk, i_rst_n, o_out.valid, o_out.held_count <= 7'(HELD_BOUND), "held count beyond window")

endmodule
